### rtl/murmur2_hash64_macros.svh
// Assertion macros for the checker file of the hash block.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef MURMUR2_HASH64_MACROS_SVH
`define MURMUR2_HASH64_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define MH64_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A consequence that must hold at the clock edge after its antecedent.
`define MH64_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`endif

### rtl/mh64_pkg.sv
package mh64_pkg;

	localparam int WORD_W      = 64;
	localparam int COUNT_W     = 4;
	localparam int LEN_W       = 32;
	localparam int BYTES       = 8;
	localparam int HALF_W      = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [WORD_W-1:0] MUR_M = 64'hc6a4a7935bd1e995;
	localparam int                MUR_R = 47;

	// How a word contributes to the running hash.
	typedef enum logic [1:0] {
		KIND_EMPTY,
		KIND_PART,
		KIND_FULL
	} kind_t;

	// One classified request as it waits between the front and the back.
	typedef struct packed {
		logic [WORD_W-1:0] data;
		kind_t             kind;
		logic              first;
		logic              last;
		logic [LEN_W-1:0]  len;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEN,
		ST_MIXA,
		ST_MIXB,
		ST_FOLD,
		ST_FIN,
		ST_OUT
	} back_state_t;

endpackage

### rtl/mh64_if.sv
interface mh64_in_if;
	logic                              valid;
	logic                              ready;
	logic [mh64_pkg::WORD_W-1:0]       word;
	logic [mh64_pkg::COUNT_W-1:0]      byte_count;
	logic                              first;
	logic                              last;
	logic [mh64_pkg::LEN_W-1:0]        message_length;

	modport source (output valid, word, byte_count, first, last, message_length, input ready);
	modport sink   (input valid, word, byte_count, first, last, message_length, output ready);
endinterface

interface mh64_out_if;
	logic                        valid;
	logic                        ready;
	logic [mh64_pkg::WORD_W-1:0] hash;

	modport source (output valid, hash, input ready);
	modport sink   (input valid, hash, output ready);
endinterface

interface mh64_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [mh64_pkg::WORD_W-1:0] seed;

	modport source (output valid, seed, input ready);
	modport sink   (input valid, seed, output ready);
endinterface

### rtl/mh64_front.sv
module mh64_front (
	input  logic            clk,
	input  logic            arst_n,
	mh64_in_if.sink         in_ch,
	output logic            q_valid,
	output mh64_pkg::item_t q_item,
	input  logic            q_pop
);

	mh64_pkg::item_t                  mem_q [mh64_pkg::QUEUE_DEPTH];
	logic [mh64_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [mh64_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [mh64_pkg::QCNT_W-1:0]      cnt_q;
	logic                             push;
	logic                             pop;
	logic [mh64_pkg::WORD_W-1:0]      mask;
	mh64_pkg::item_t                  item_in;

	// Byte mask for a partial word: bytes below the count are kept.
	always_comb begin
		for (int i = 0; i < mh64_pkg::BYTES; i++) begin
			mask[i*8 +: 8] = (mh64_pkg::COUNT_W'(i) < in_ch.byte_count) ? 8'hFF : 8'h00;
		end
	end

	always_comb begin
		item_in.first = in_ch.first;
		item_in.last  = in_ch.last;
		item_in.len   = in_ch.message_length;
		if (in_ch.byte_count >= mh64_pkg::COUNT_W'(mh64_pkg::BYTES)) begin
			item_in.kind = mh64_pkg::KIND_FULL;
			item_in.data = in_ch.word;
		end else if (in_ch.byte_count != '0) begin
			item_in.kind = mh64_pkg::KIND_PART;
			item_in.data = in_ch.word & mask;
		end else begin
			item_in.kind = mh64_pkg::KIND_EMPTY;
			item_in.data = in_ch.word;
		end
	end

	assign in_ch.ready = (cnt_q != mh64_pkg::QCNT_W'(mh64_pkg::QUEUE_DEPTH));
	assign push        = in_ch.valid && in_ch.ready;
	assign q_valid     = (cnt_q != '0);
	assign pop         = q_pop && q_valid;
	assign q_item      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### rtl/mh64_mul.sv
module mh64_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [mh64_pkg::WORD_W-1:0] a,
	output logic                        done,
	output logic [mh64_pkg::WORD_W-1:0] product
);

	localparam logic [mh64_pkg::HALF_W-1:0] M_LO = mh64_pkg::MUR_M[mh64_pkg::HALF_W-1:0];
	localparam logic [mh64_pkg::HALF_W-1:0] M_HI =
		mh64_pkg::MUR_M[mh64_pkg::WORD_W-1:mh64_pkg::HALF_W];

	logic [mh64_pkg::HALF_W-1:0] a_lo;
	logic [mh64_pkg::HALF_W-1:0] a_hi;
	logic [mh64_pkg::WORD_W-1:0] prod_ll;
	logic [mh64_pkg::HALF_W-1:0] prod_lh;
	logic [mh64_pkg::HALF_W-1:0] prod_hl;
	logic [mh64_pkg::WORD_W-1:0] ll_s1;
	logic [mh64_pkg::HALF_W-1:0] lh_s1;
	logic [mh64_pkg::HALF_W-1:0] hl_s1;
	logic [mh64_pkg::HALF_W-1:0] cross_sum;
	logic                        valid_s1;
	logic                        valid_s2;
	logic [mh64_pkg::WORD_W-1:0] prod_s2;

	assign a_lo    = a[mh64_pkg::HALF_W-1:0];
	assign a_hi    = a[mh64_pkg::WORD_W-1:mh64_pkg::HALF_W];

	// Low 64 bits of a * M from three 32 by 32 partial products.
	assign prod_ll   = {{mh64_pkg::HALF_W{1'b0}}, a_lo} * {{mh64_pkg::HALF_W{1'b0}}, M_LO};
	assign prod_lh   = a_lo * M_HI;
	assign prod_hl   = a_hi * M_LO;
	assign cross_sum = lh_s1 + hl_s1;

	always_ff @(posedge clk) begin
		ll_s1   <= prod_ll;
		lh_s1   <= prod_lh;
		hl_s1   <= prod_hl;
		if (valid_s1) begin
			prod_s2 <= ll_s1 + {cross_sum, {mh64_pkg::HALF_W{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	assign done    = valid_s2;
	assign product = prod_s2;

endmodule

### rtl/mh64_back.sv
module mh64_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  mh64_pkg::item_t             q_item,
	output logic                        q_pop,
	input  logic [mh64_pkg::WORD_W-1:0] seed,
	mh64_out_if.source                  out_ch
);

	mh64_pkg::back_state_t       state_q;
	mh64_pkg::back_state_t       state_d;
	mh64_pkg::item_t             cur_q;
	logic                        cur_we;
	logic [mh64_pkg::WORD_W-1:0] h_q;
	logic [mh64_pkg::WORD_W-1:0] h_d;
	logic                        h_we;
	logic                        mul_start;
	logic [mh64_pkg::WORD_W-1:0] mul_a;
	logic                        mul_done;
	logic [mh64_pkg::WORD_W-1:0] product;
	logic                        body_go;
	logic [mh64_pkg::WORD_W-1:0] body_h;
	mh64_pkg::item_t             body_item;
	logic                        tail_go;
	logic [mh64_pkg::WORD_W-1:0] tail_h;
	logic                        tail_last;
	logic                        out_load;
	logic                        out_valid_q;
	logic [mh64_pkg::WORD_W-1:0] out_hash_q;

	mh64_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.done    (mul_done),
		.product (product)
	);

	always_comb begin
		state_d   = state_q;
		cur_we    = 1'b0;
		q_pop     = 1'b0;
		h_we      = 1'b0;
		h_d       = h_q;
		mul_start = 1'b0;
		mul_a     = '0;
		body_go   = 1'b0;
		body_h    = h_q;
		body_item = cur_q;
		tail_go   = 1'b0;
		tail_h    = h_q;
		tail_last = cur_q.last;
		out_load  = 1'b0;

		unique case (state_q)
			mh64_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop  = 1'b1;
					cur_we = 1'b1;
					if (q_item.first) begin
						mul_start = 1'b1;
						mul_a     = {{(mh64_pkg::WORD_W-mh64_pkg::LEN_W){1'b0}}, q_item.len};
						state_d   = mh64_pkg::ST_LEN;
					end else begin
						body_go   = 1'b1;
						body_h    = h_q;
						body_item = q_item;
					end
				end
			end
			mh64_pkg::ST_LEN: begin
				if (mul_done) begin
					h_we    = 1'b1;
					h_d     = seed ^ product;
					body_go = 1'b1;
					body_h  = seed ^ product;
				end
			end
			mh64_pkg::ST_MIXA: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = product ^ (product >> mh64_pkg::MUR_R);
					state_d   = mh64_pkg::ST_MIXB;
				end
			end
			mh64_pkg::ST_MIXB: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = h_q ^ product;
					state_d   = mh64_pkg::ST_FOLD;
				end
			end
			mh64_pkg::ST_FOLD: begin
				if (mul_done) begin
					h_we    = 1'b1;
					h_d     = product;
					tail_go = 1'b1;
					tail_h  = product;
				end
			end
			mh64_pkg::ST_FIN: begin
				if (mul_done) begin
					state_d = mh64_pkg::ST_OUT;
				end
			end
			mh64_pkg::ST_OUT: begin
				if (!out_valid_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = mh64_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mh64_pkg::ST_IDLE;
			end
		endcase

		// Start of the word's own contribution, once the base hash is known.
		if (body_go) begin
			tail_last = body_item.last;
			unique case (body_item.kind)
				mh64_pkg::KIND_FULL: begin
					mul_start = 1'b1;
					mul_a     = body_item.data;
					state_d   = mh64_pkg::ST_MIXA;
				end
				mh64_pkg::KIND_PART: begin
					mul_start = 1'b1;
					mul_a     = body_h ^ body_item.data;
					state_d   = mh64_pkg::ST_FOLD;
				end
				mh64_pkg::KIND_EMPTY: begin
					tail_go = 1'b1;
					tail_h  = body_h;
				end
				default: begin
					tail_go = 1'b1;
					tail_h  = body_h;
				end
			endcase
		end

		// After the word: finalise on the last word, otherwise take the next request.
		if (tail_go) begin
			if (tail_last) begin
				mul_start = 1'b1;
				mul_a     = tail_h ^ (tail_h >> mh64_pkg::MUR_R);
				state_d   = mh64_pkg::ST_FIN;
			end else begin
				state_d = mh64_pkg::ST_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mh64_pkg::ST_IDLE;
			h_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (h_we) begin
				h_q <= h_d;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cur_we) begin
			cur_q <= q_item;
		end
		if (out_load) begin
			out_hash_q <= product ^ (product >> mh64_pkg::MUR_R);
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.hash  = out_hash_q;

endmodule

### rtl/murmur2_hash64.sv
// Streaming 64-bit MurmurHash64A. A message arrives as little-endian 64-bit words on
// in_ch; the first word of a message carries the total length in message_length, and
// the word marked last produces one finished hash on out_ch. Each word is classified
// on entry (full, partial with its unused bytes masked, or empty) and placed in a
// two-entry queue, so the sender can run up to two requests ahead of the arithmetic.
// All arithmetic goes through one shared 64-bit multiplier by the MurmurHash constant,
// built from three 32 by 32 partial products. A full word is dispatched and then
// takes three dependent multiplies, a partial word one multiply and an empty word
// none; the first word of a message adds a multiply of the length to seed the hash,
// and the last word adds the final avalanche multiply and the hand-over to the
// output register. A finished hash waits in that register while the next
// message is already being worked on. The seed is written on cfg_ch, which is always
// ready; it must be written only while no message is in flight. The length is
// trusted as given and the running hash carries over between messages when a word
// arrives without its first mark.
module murmur2_hash64 (
	input  logic       clk,
	input  logic       arst_n,
	mh64_in_if.sink    in_ch,
	mh64_out_if.source out_ch,
	mh64_cfg_if.sink   cfg_ch
);

	logic [mh64_pkg::WORD_W-1:0] seed_q;
	logic                        q_valid;
	logic                        q_pop;
	mh64_pkg::item_t             q_item;

	// The seed register accepts a write in every cycle.
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_ch.valid) begin
			seed_q <= cfg_ch.seed;
		end
	end

	// Front end: takes requests, classifies and masks them, and queues them.
	mh64_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	// Back end: the sequencer around the shared multiplier and the output register.
	mh64_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.seed    (seed_q),
		.out_ch  (out_ch)
	);

endmodule

### rtl/murmur2_hash64_chk.sv
`include "murmur2_hash64_macros.svh"

module murmur2_hash64_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [mh64_pkg::WORD_W-1:0] out_hash,
	input logic                        cfg_ready
);

	// A waiting result is neither dropped nor altered until it is taken.
	`MH64_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_hash), "result changed while stalled")

	// The seed register never stalls a write.
	`MH64_ASSERT(a_cfg_ready, cfg_ready, "configuration port not ready")

	// Straight after reset the queue is empty and takes requests.
	`MH64_ASSERT(a_in_ready_rst, !$past(arst_n) |-> in_ready, "input not ready after reset")

	// No result can be pending straight after reset.
	`MH64_ASSERT(a_out_idle_rst, !$past(arst_n) |-> !out_valid, "result valid after reset")

endmodule

bind murmur2_hash64 murmur2_hash64_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_hash  (out_ch.hash),
	.cfg_ready (cfg_ch.ready)
);

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

	// One request on the input channel, in the block's own field widths.
	typedef struct packed {
		logic [mh64_pkg::WORD_W-1:0]  word;
		logic [mh64_pkg::COUNT_W-1:0] byte_count;
		logic                         first;
		logic                         last;
		logic [mh64_pkg::LEN_W-1:0]   message_length;
	} hash_req_t;

	// A row of the directed table. Where the hash can be read straight off the
	// arithmetic, it is typed in and checked as it stands. Every other row is
	// checked against the predictor.
	typedef struct packed {
		hash_req_t                   req;
		logic                        typed;
		logic [mh64_pkg::WORD_W-1:0] typed_hash;
	} directed_row_t;

	localparam int NUM_DIRECTED = 17;
	localparam int NUM_PHASES   = 6;
	localparam int PHASE_ITEMS  = 325;
	// An item that yields no hash can still be inside the block (two queue
	// entries plus a seeded, full, finalised word) after the last hash is out.
	localparam int DRAIN_CYCLES = 40;
	// The slowest correct run is roughly 2000 requests, each with its block time,
	// sender gap and receiver stall. The limit allows several times that.
	localparam int CYCLE_LIMIT  = 400000;

	logic clk = 1'b0;
	logic arst_n;

	mh64_in_if  in_ch ();
	mh64_out_if out_ch ();
	mh64_cfg_if cfg_ch ();

	murmur2_hash64 u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	// A 20 ns clock; the testbench drives on the falling edge and samples on the
	// rising edge, so nothing it sees depends on event order within a step.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The predictor's own copy of the block's state and its seed register.
	logic [mh64_pkg::WORD_W-1:0] seed_value;
	logic [mh64_pkg::WORD_W-1:0] hash_state;

	// Finished hashes still owed by the block, oldest first.
	logic [mh64_pkg::WORD_W-1:0] hash_expected [$];

	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned requests_sent;

	// Random idling on each side is switched per phase; the final phase runs
	// with both switched off so that the block is driven flat out.
	bit input_idle_on;
	bit output_idle_on;
	int unsigned output_stall_left = 0;

	directed_row_t directed_rows [NUM_DIRECTED] = '{
		// No first mark straight after reset: the hash is still zero, an empty
		// word adds nothing, and the avalanche of zero is zero.
		'{'{64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0, 1'b1, 32'd0}, 1'b1, 64'h0},
		// An empty message with a zero seed and a zero length also gives zero.
		'{'{64'h0000_0000_0000_0000, 4'd0, 1'b1, 1'b1, 32'd0}, 1'b1, 64'h0},
		// A single full word of all ones.
		'{'{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 1'b1, 32'd8}, 1'b0, 64'h0},
		// A byte count above eight counts as a full word; largest length.
		'{'{64'h0123_4567_89AB_CDEF, 4'd15, 1'b1, 1'b0, 32'hFFFF_FFFF}, 1'b0, 64'h0},
		// A partial word in the middle of a message.
		'{'{64'hFEDC_BA98_7654_3210, 4'd3, 1'b0, 1'b0, 32'h0}, 1'b0, 64'h0},
		'{'{64'h8000_0000_0000_0001, 4'd9, 1'b0, 1'b0, 32'hFFFF_FFFF}, 1'b0, 64'h0},
		'{'{64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b0, 1'b1, 32'h0}, 1'b0, 64'h0},
		// A well-formed sixteen-byte message closed by an empty word; the
		// length on the second word is ignored.
		'{'{64'h0000_0000_0000_0000, 4'd8, 1'b1, 1'b0, 32'd16}, 1'b0, 64'h0},
		'{'{64'hA5A5_A5A5_A5A5_A5A5, 4'd8, 1'b0, 1'b0, 32'hDEAD_BEEF}, 1'b0, 64'h0},
		'{'{64'h0000_0000_0000_0000, 4'd0, 1'b0, 1'b1, 32'h0}, 1'b0, 64'h0},
		// A message without a first mark carries on from the last running hash.
		'{'{64'hFFFF_FFFF_FFFF_FFFF, 4'd7, 1'b0, 1'b1, 32'h0}, 1'b0, 64'h0},
		'{'{64'h1122_3344_5566_7788, 4'd4, 1'b1, 1'b1, 32'd4}, 1'b0, 64'h0},
		'{'{64'h8000_0000_0000_0000, 4'd8, 1'b1, 1'b1, 32'd8}, 1'b0, 64'h0},
		// A length that disagrees with the bytes delivered is trusted as given.
		'{'{64'h5555_5555_5555_5555, 4'd6, 1'b1, 1'b0, 32'h8000_0000}, 1'b0, 64'h0},
		'{'{64'hAAAA_AAAA_AAAA_AAAA, 4'd2, 1'b0, 1'b1, 32'h7FFF_FFFF}, 1'b0, 64'h0},
		// A second first mark in the middle of a message starts afresh.
		'{'{64'h0000_0000_0000_0000, 4'd0, 1'b1, 1'b0, 32'd0}, 1'b0, 64'h0},
		'{'{64'h0000_00FF_FFFF_FFFF, 4'd5, 1'b1, 1'b1, 32'd5}, 1'b0, 64'h0}
	};

	// The per-word mix: multiply, fold the top bits down, multiply again.
	function automatic logic [mh64_pkg::WORD_W-1:0] scramble_word(
			input logic [mh64_pkg::WORD_W-1:0] k);
		k = k * mh64_pkg::MUR_M;
		k = k ^ (k >> mh64_pkg::MUR_R);
		k = k * mh64_pkg::MUR_M;
		return k;
	endfunction

	// The final avalanche. It only feeds the output; the running hash keeps
	// the value from before it.
	function automatic logic [mh64_pkg::WORD_W-1:0] finish_hash(
			input logic [mh64_pkg::WORD_W-1:0] h);
		h = h ^ (h >> mh64_pkg::MUR_R);
		h = h * mh64_pkg::MUR_M;
		h = h ^ (h >> mh64_pkg::MUR_R);
		return h;
	endfunction

	// Folds one accepted request into the running hash and says whether it
	// closes a message, and if so with which hash.
	function automatic void absorb_request(input hash_req_t r, output bit done,
			output logic [mh64_pkg::WORD_W-1:0] digest);
		logic [mh64_pkg::WORD_W-1:0] h;
		int nbytes;
		h = r.first ? (seed_value ^ ({32'b0, r.message_length} * mh64_pkg::MUR_M))
			: hash_state;
		nbytes = (r.byte_count >= 8) ? 8 : int'(r.byte_count);
		if (nbytes == 8) begin
			h = (h ^ scramble_word(r.word)) * mh64_pkg::MUR_M;
		end else if (nbytes != 0) begin
			// Only the valid low bytes of a partial word take part.
			h = (h ^ (r.word & ((64'd1 << (8 * nbytes)) - 64'd1))) * mh64_pkg::MUR_M;
		end
		hash_state = h;
		done = r.last;
		digest = finish_hash(h);
	endfunction

	// Offers one request, after an idle burst now and then, and holds it until
	// the block takes it. The prediction is made at the edge of acceptance.
	task automatic push_request(input hash_req_t r, input bit typed,
			input logic [mh64_pkg::WORD_W-1:0] typed_hash);
		bit done;
		logic [mh64_pkg::WORD_W-1:0] digest;
		@(negedge clk);
		if (input_idle_on && $urandom_range(0, 3) == 0) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_ch.word           = r.word;
		in_ch.byte_count     = r.byte_count;
		in_ch.first          = r.first;
		in_ch.last           = r.last;
		in_ch.message_length = r.message_length;
		in_ch.valid          = 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		absorb_request(r, done, digest);
		if (done) begin
			hash_expected.push_back(typed ? typed_hash : digest);
		end
		requests_sent++;
	endtask

	// Lowers the request, then waits until every owed hash is out and the
	// block has had time to finish any word that yields none.
	task automatic settle_block();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (hash_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(input logic [mh64_pkg::WORD_W-1:0] value);
		@(negedge clk);
		cfg_ch.seed  = value;
		cfg_ch.valid = 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		seed_value = value;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Sends one message of random content. Most are well formed: a first word
	// carrying the length, full words, and a tail of 0 to 7 bytes that closes
	// it (or a full word marked last when there is no tail). A few lengths are
	// random, since the block must trust them. The rest are broken sequences
	// with random counts and marks, still closed by a last word so that each
	// phase ends on a message boundary.
	task automatic send_message();
		hash_req_t parts [$];
		hash_req_t r;
		int nfull;
		int tail;
		int nnoise;
		logic [mh64_pkg::LEN_W-1:0] len;
		if ($urandom_range(0, 99) < 80) begin
			nfull = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
			tail  = $urandom_range(0, 7);
			len   = mh64_pkg::LEN_W'(nfull * 8 + tail);
			if ($urandom_range(0, 9) == 0) begin
				len = $urandom();
			end
			for (int i = 0; i < nfull; i++) begin
				r.word           = {$urandom(), $urandom()};
				r.byte_count     = 4'd8;
				r.first          = (i == 0);
				r.last           = 1'b0;
				r.message_length = (i == 0) ? len : $urandom();
				parts.push_back(r);
			end
			if (tail != 0 || nfull == 0 || $urandom_range(0, 1) == 0) begin
				r.word           = {$urandom(), $urandom()};
				r.byte_count     = mh64_pkg::COUNT_W'(tail);
				r.first          = (nfull == 0);
				r.last           = 1'b1;
				r.message_length = (nfull == 0) ? len : $urandom();
				parts.push_back(r);
			end else begin
				parts[parts.size() - 1].last = 1'b1;
			end
		end else begin
			nnoise = $urandom_range(1, 6);
			for (int i = 0; i < nnoise; i++) begin
				r.word           = {$urandom(), $urandom()};
				r.byte_count     = mh64_pkg::COUNT_W'($urandom_range(0, 15));
				r.first          = 1'($urandom_range(0, 1));
				r.last           = (i == nnoise - 1) ? 1'b1 : 1'(($urandom_range(0, 3) == 0));
				r.message_length = $urandom();
				parts.push_back(r);
			end
		end
		foreach (parts[i]) begin
			push_request(parts[i], 1'b0, '0);
		end
	endtask

	// The receiver takes hashes with stalls now and then.
	always @(negedge clk) begin
		if (output_stall_left != 0) begin
			output_stall_left--;
			out_ch.ready = 1'b0;
		end else if (output_idle_on && $urandom_range(0, 4) == 0) begin
			output_stall_left = $urandom_range(1, 4) - 1;
			out_ch.ready = 1'b0;
		end else begin
			out_ch.ready = 1'b1;
		end
	end

	// Each hash the block hands over is compared with the oldest one owed.
	always @(posedge clk) begin : check_hashes
		logic [mh64_pkg::WORD_W-1:0] want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (hash_expected.size() == 0) begin
				$display("%0t: hash %h arrived with none expected", $time, out_ch.hash);
				error_count++;
			end else begin
				want = hash_expected.pop_front();
				if (out_ch.hash !== want) begin
					$display("%0t: hash mismatch, expected %h, actual %h",
						$time, want, out_ch.hash);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		logic [mh64_pkg::WORD_W-1:0] phase_seed [NUM_PHASES];
		phase_seed = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, {$urandom(), $urandom()},
			64'h1, 64'h8000_0000_0000_0000, {$urandom(), $urandom()}};

		// Every input is known from the first instant.
		in_ch.valid          = 1'b0;
		in_ch.word           = '0;
		in_ch.byte_count     = '0;
		in_ch.first          = 1'b0;
		in_ch.last           = 1'b0;
		in_ch.message_length = '0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.seed          = '0;
		out_ch.ready         = 1'b0;
		input_idle_on        = 1'b1;
		output_idle_on       = 1'b1;
		requests_sent        = 0;
		seed_value           = '0;
		hash_state           = '0;

		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed requests run on the seed left by reset.
		foreach (directed_rows[i]) begin
			push_request(directed_rows[i].req, directed_rows[i].typed,
				directed_rows[i].typed_hash);
		end

		// Random phases, each under a seed of its own. The seed is only ever
		// changed with the block drained. Idling is varied between phases,
		// with none at all in the last one.
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			settle_block();
			write_seed(phase_seed[phase]);
			input_idle_on  = (phase != 3) && (phase != NUM_PHASES - 1);
			output_idle_on = (phase != 2) && (phase != NUM_PHASES - 1);
			requests_sent  = 0;
			while (requests_sent < PHASE_ITEMS) begin
				send_message();
			end
		end

		settle_block();
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
